>>> design/ajet_pkg.sv
package ajet_pkg;

   localparam int PIXEL_W = 10;
   localparam int Q_W = 32;
   localparam int FRAC_BITS = 24;
   localparam int COUNT_W = 16;
   localparam int COLOR_W = 8;
   localparam int GAINS_W = 24;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [64:0] ESCAPE_LIMIT = 65'(8) << (2 * FRAC_BITS);
   localparam logic [COUNT_W-1:0] MAX_ITER_RESET = COUNT_W'(50);

   typedef enum logic [2:0] {
      CSR_C_RE,
      CSR_C_IM,
      CSR_ORIGIN_X,
      CSR_ORIGIN_Y,
      CSR_STEP_X,
      CSR_STEP_Y,
      CSR_MAX_ITER,
      CSR_COLOR_GAINS
   } csr_index_type;

   // Clamps a wide signed value to the signed Q8.24 range.
   function automatic logic [Q_W-1:0] sat_q(input logic signed [67:0] v);
      logic [Q_W-1:0] r;
      if (v[67] && !(&v[66:31])) begin
         r = {1'b1, {(Q_W-1){1'b0}}};
      end else if (!v[67] && (|v[66:31])) begin
         r = {1'b0, {(Q_W-1){1'b1}}};
      end else begin
         r = v[Q_W-1:0];
      end
      return r;
   endfunction

endpackage

>>> design/ajet_req_if.sv
interface ajet_req_if;
   logic                          valid;
   logic                          ready;
   logic [ajet_pkg::PIXEL_W-1:0]  pixel_x;
   logic [ajet_pkg::PIXEL_W-1:0]  pixel_y;

   modport source(output valid, pixel_x, pixel_y, input ready);
   modport sink(input valid, pixel_x, pixel_y, output ready);
endinterface

>>> design/ajet_rsp_if.sv
interface ajet_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ajet_pkg::COUNT_W-1:0]  iteration_count;
   logic                          inside_res;
   logic [ajet_pkg::COLOR_W-1:0]  blue;
   logic [ajet_pkg::COLOR_W-1:0]  green;
   logic [ajet_pkg::COLOR_W-1:0]  red;

   modport source(output valid, iteration_count, inside_res, blue, green, red, input ready);
   modport sink(input valid, iteration_count, inside_res, blue, green, red, output ready);
endinterface

>>> design/abs_julia_escape_time_pixel.sv
// Escape-time evaluator for one pixel of an absolute-value Julia set.
// The req channel carries a pixel column and row; the rsp channel returns
// the iteration count, an inside flag and three color bytes for it.
// A transfer happens on a clock edge where valid and ready are both high.
// The block takes one pixel at a time: req ready is high only while the
// sequencer is idle. The pixel is mapped to its start value in states
// MAP_X, MAP_Y and MAP_ADD; each iteration runs MUL_RR, MUL_II, TEST and
// UPDATE, the final escape test runs MUL_RR, MUL_II and TEST, and the
// result is loaded in DONE. The sequencer is idle again after that load.
// One shared 33 by 33 bit multiplier, used at most once per cycle, forms
// every product in the mapping, squaring and cross-term steps.
// The result waits in an output register; if the receiver stalls, the
// finished pixel holds there while the next pixel is already accepted and
// computed, and that one waits before loading until the register is free.
// The user must write the registers through the APB port only while the block is idle; the block does not enforce it.
// Synchronous reset returns the sequencer to idle, drops rsp valid and
// sets all APB registers to zero except the iteration limit, which becomes 50.
module abs_julia_escape_time_pixel (
   input  logic                                  clock,
   input  logic                                  reset,
   ajet_req_if.sink                              req_bus,
   ajet_rsp_if.source                            rsp_bus,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [ajet_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [ajet_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [ajet_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                  pready
);

   typedef enum logic [3:0] {
      IDLE,
      MAP_X,
      MAP_Y,
      MAP_ADD,
      MUL_RR,
      MUL_II,
      TEST,
      UPDATE,
      DONE
   } state_type;

   state_type state_ff, state_in;

   logic [31:0] c_re_ff, c_im_ff, origin_x_ff, origin_y_ff, step_x_ff, step_y_ff;
   logic [31:0] c_re_in, c_im_in, origin_x_in, origin_y_in, step_x_in, step_y_in;
   logic [ajet_pkg::COUNT_W-1:0] max_iter_ff, max_iter_in;
   logic [ajet_pkg::GAINS_W-1:0] color_gains_ff, color_gains_in;

   logic [ajet_pkg::PIXEL_W-1:0] px_ff, px_in, py_ff, py_in;
   logic [31:0] re_ff, re_in, im_ff, im_in;
   logic signed [65:0] prod_ff, prod_in;
   logic [63:0] r2_ff, r2_in;
   logic signed [64:0] d_ff, d_in;
   logic [ajet_pkg::COUNT_W-1:0] count_ff, count_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [ajet_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic rsp_inside_ff, rsp_inside_in;
   logic [ajet_pkg::COLOR_W-1:0] rsp_blue_ff, rsp_blue_in;
   logic [ajet_pkg::COLOR_W-1:0] rsp_green_ff, rsp_green_in;
   logic [ajet_pkg::COLOR_W-1:0] rsp_red_ff, rsp_red_in;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p;
   logic [31:0] ar, ai;
   logic [64:0] mag_sum;
   logic signed [67:0] prod_ext, d_shift, p_shift;
   logic signed [67:0] c_re_ext, c_im_ext, origin_x_ext, origin_y_ext;
   logic [15:0] blue_p, green_p, red_p;
   logic limit_hit;
   logic csr_write;

   assign mul_p = mul_a * mul_b;

   assign ar = re_ff[31] ? (~re_ff + 32'd1) : re_ff;
   assign ai = im_ff[31] ? (~im_ff + 32'd1) : im_ff;
   assign mag_sum = {1'b0, r2_ff} + {1'b0, prod_ff[63:0]};

   assign prod_ext = $signed({{2{prod_ff[65]}}, prod_ff});
   assign d_shift = $signed({{3{d_ff[64]}}, d_ff}) >>> ajet_pkg::FRAC_BITS;
   assign p_shift = prod_ext >>> (ajet_pkg::FRAC_BITS - 1);
   assign c_re_ext = $signed({{36{c_re_ff[31]}}, c_re_ff});
   assign c_im_ext = $signed({{36{c_im_ff[31]}}, c_im_ff});
   assign origin_x_ext = $signed({{36{origin_x_ff[31]}}, origin_x_ff});
   assign origin_y_ext = $signed({{36{origin_y_ff[31]}}, origin_y_ff});

   assign limit_hit = (count_ff == max_iter_ff);
   assign blue_p = count_ff[7:0] * color_gains_ff[7:0];
   assign green_p = count_ff[7:0] * color_gains_ff[15:8];
   assign red_p = count_ff[7:0] * color_gains_ff[23:16];

   assign csr_write = psel && penable && pwrite;
   assign pready = 1'b1;

   assign req_bus.ready = (state_ff == IDLE);
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.iteration_count = rsp_count_ff;
   assign rsp_bus.inside_res = rsp_inside_ff;
   assign rsp_bus.blue = rsp_blue_ff;
   assign rsp_bus.green = rsp_green_ff;
   assign rsp_bus.red = rsp_red_ff;

   always_comb begin
      unique case (ajet_pkg::csr_index_type'(paddr[4:2]))
         ajet_pkg::CSR_C_RE:        prdata = c_re_ff;
         ajet_pkg::CSR_C_IM:        prdata = c_im_ff;
         ajet_pkg::CSR_ORIGIN_X:    prdata = origin_x_ff;
         ajet_pkg::CSR_ORIGIN_Y:    prdata = origin_y_ff;
         ajet_pkg::CSR_STEP_X:      prdata = step_x_ff;
         ajet_pkg::CSR_STEP_Y:      prdata = step_y_ff;
         ajet_pkg::CSR_MAX_ITER:    prdata = {16'd0, max_iter_ff};
         ajet_pkg::CSR_COLOR_GAINS: prdata = {8'd0, color_gains_ff};
         default:                   prdata = '0;
      endcase
   end

   always_comb begin
      c_re_in = c_re_ff;
      c_im_in = c_im_ff;
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      step_x_in = step_x_ff;
      step_y_in = step_y_ff;
      max_iter_in = max_iter_ff;
      color_gains_in = color_gains_ff;
      if (csr_write) begin
         unique case (ajet_pkg::csr_index_type'(paddr[4:2]))
            ajet_pkg::CSR_C_RE:        c_re_in = pwdata;
            ajet_pkg::CSR_C_IM:        c_im_in = pwdata;
            ajet_pkg::CSR_ORIGIN_X:    origin_x_in = pwdata;
            ajet_pkg::CSR_ORIGIN_Y:    origin_y_in = pwdata;
            ajet_pkg::CSR_STEP_X:      step_x_in = pwdata;
            ajet_pkg::CSR_STEP_Y:      step_y_in = pwdata;
            ajet_pkg::CSR_MAX_ITER:    max_iter_in = pwdata[15:0];
            ajet_pkg::CSR_COLOR_GAINS: color_gains_in = pwdata[23:0];
            default:                   max_iter_in = max_iter_ff;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      px_in = px_ff;
      py_in = py_ff;
      re_in = re_ff;
      im_in = im_ff;
      prod_in = prod_ff;
      r2_in = r2_ff;
      d_in = d_ff;
      count_in = count_ff;
      mul_a = '0;
      mul_b = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_count_in = rsp_count_ff;
      rsp_inside_in = rsp_inside_ff;
      rsp_blue_in = rsp_blue_ff;
      rsp_green_in = rsp_green_ff;
      rsp_red_in = rsp_red_ff;

      unique case (state_ff)
         IDLE: begin
            if (req_bus.valid) begin
               px_in = req_bus.pixel_x;
               py_in = req_bus.pixel_y;
               state_in = MAP_X;
            end
         end
         MAP_X: begin
            mul_a = $signed({23'd0, px_ff});
            mul_b = $signed({step_x_ff[31], step_x_ff});
            prod_in = mul_p;
            state_in = MAP_Y;
         end
         MAP_Y: begin
            re_in = ajet_pkg::sat_q(prod_ext + origin_x_ext);
            mul_a = $signed({23'd0, py_ff});
            mul_b = $signed({step_y_ff[31], step_y_ff});
            prod_in = mul_p;
            state_in = MAP_ADD;
         end
         MAP_ADD: begin
            im_in = ajet_pkg::sat_q(prod_ext + origin_y_ext);
            count_in = '0;
            state_in = MUL_RR;
         end
         MUL_RR: begin
            mul_a = $signed({1'b0, ar});
            mul_b = $signed({1'b0, ar});
            prod_in = mul_p;
            state_in = MUL_II;
         end
         MUL_II: begin
            r2_in = prod_ff[63:0];
            mul_a = $signed({1'b0, ai});
            mul_b = $signed({1'b0, ai});
            prod_in = mul_p;
            state_in = TEST;
         end
         TEST: begin
            if (mag_sum >= ajet_pkg::ESCAPE_LIMIT || count_ff >= max_iter_ff) begin
               state_in = DONE;
            end else begin
               d_in = $signed({1'b0, r2_ff}) - $signed({1'b0, prod_ff[63:0]});
               mul_a = $signed({1'b0, ai});
               mul_b = $signed({re_ff[31], re_ff});
               prod_in = mul_p;
               state_in = UPDATE;
            end
         end
         UPDATE: begin
            re_in = ajet_pkg::sat_q(d_shift + c_re_ext);
            im_in = ajet_pkg::sat_q(p_shift + c_im_ext);
            count_in = count_ff + 16'd1;
            state_in = MUL_RR;
         end
         DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = count_ff;
               rsp_inside_in = limit_hit;
               rsp_blue_in = limit_hit ? 8'd0 : blue_p[7:0];
               rsp_green_in = limit_hit ? 8'd0 : green_p[7:0];
               rsp_red_in = limit_hit ? 8'd0 : red_p[7:0];
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         rsp_valid_ff <= 1'b0;
         c_re_ff <= '0;
         c_im_ff <= '0;
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         step_x_ff <= '0;
         step_y_ff <= '0;
         max_iter_ff <= ajet_pkg::MAX_ITER_RESET;
         color_gains_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         c_re_ff <= c_re_in;
         c_im_ff <= c_im_in;
         origin_x_ff <= origin_x_in;
         origin_y_ff <= origin_y_in;
         step_x_ff <= step_x_in;
         step_y_ff <= step_y_in;
         max_iter_ff <= max_iter_in;
         color_gains_ff <= color_gains_in;
      end
      px_ff <= px_in;
      py_ff <= py_in;
      re_ff <= re_in;
      im_ff <= im_in;
      prod_ff <= prod_in;
      r2_ff <= r2_in;
      d_ff <= d_in;
      count_ff <= count_in;
      rsp_count_ff <= rsp_count_in;
      rsp_inside_ff <= rsp_inside_in;
      rsp_blue_ff <= rsp_blue_in;
      rsp_green_ff <= rsp_green_in;
      rsp_red_ff <= rsp_red_in;
   end

endmodule

>>> tb/sv/tb_abs_julia_escape_time_pixel.sv
`timescale 1ns / 100ps

module tb_abs_julia_escape_time_pixel;

   localparam int CSR_COUNT = ajet_pkg::CSR_COLOR_GAINS + 1;
   localparam int STALL_LIMIT = 1_000_000;
   localparam int TAIL_CYCLES = 20;
   localparam longint unsigned ESCAPE_BOUND = 64'd8 << (2 * ajet_pkg::FRAC_BITS);
   localparam longint Q_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam longint Q_MIN = -Q_MAX - 1;
   localparam int PIXEL_MAX = (1 << ajet_pkg::PIXEL_W) - 1;

   typedef logic [ajet_pkg::PIXEL_W-1:0] pixel_coord_type;
   typedef logic [ajet_pkg::COUNT_W-1:0] count_type;
   typedef logic [ajet_pkg::COLOR_W-1:0] color_type;

   typedef struct packed {
      logic [ajet_pkg::COUNT_W-1:0] iteration_count;
      logic                         inside_res;
      logic [ajet_pkg::COLOR_W-1:0] blue;
      logic [ajet_pkg::COLOR_W-1:0] green;
      logic [ajet_pkg::COLOR_W-1:0] red;
   } pixel_result_type;

   logic                            clock;
   logic                            reset;
   logic                            psel;
   logic                            penable;
   logic                            pwrite;
   logic [ajet_pkg::CSR_ADDR_W-1:0] paddr;
   logic [ajet_pkg::CSR_DATA_W-1:0] pwdata;
   logic [ajet_pkg::CSR_DATA_W-1:0] prdata;
   logic                            pready;

   ajet_req_if req_bus();
   ajet_rsp_if rsp_bus();

   abs_julia_escape_time_pixel dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   logic [ajet_pkg::CSR_DATA_W-1:0] shadow_regs [CSR_COUNT];
   pixel_result_type                expected_pixels [$];
   int                              error_count = 0;
   bit                              no_idling = 1'b0;
   int                              rsp_hold_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [ajet_pkg::CSR_DATA_W-1:0] reg_mask(
         input ajet_pkg::csr_index_type idx);
      case (idx)
         ajet_pkg::CSR_MAX_ITER: return 32'h0000_FFFF;
         ajet_pkg::CSR_COLOR_GAINS: return 32'h00FF_FFFF;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   function automatic longint as_q(input logic [ajet_pkg::Q_W-1:0] v);
      return longint'(signed'(v));
   endfunction

   function automatic longint clamp_q(input longint v);
      if (v > Q_MAX) return Q_MAX;
      if (v < Q_MIN) return Q_MIN;
      return v;
   endfunction

   function automatic pixel_result_type escape_time(input pixel_coord_type col,
                                                    input pixel_coord_type row);
      longint                       re;
      longint                       im;
      longint                       cr;
      longint                       ci;
      longint                       d;
      longint                       p;
      longint unsigned              ar;
      longint unsigned              ai;
      longint unsigned              r2;
      longint unsigned              i2;
      int unsigned                  count;
      logic [ajet_pkg::COUNT_W-1:0] limit_iter;
      logic [ajet_pkg::GAINS_W-1:0] gains;
      pixel_result_type             res;
      limit_iter = shadow_regs[ajet_pkg::CSR_MAX_ITER][ajet_pkg::COUNT_W-1:0];
      gains = shadow_regs[ajet_pkg::CSR_COLOR_GAINS][ajet_pkg::GAINS_W-1:0];
      cr = as_q(shadow_regs[ajet_pkg::CSR_C_RE]);
      ci = as_q(shadow_regs[ajet_pkg::CSR_C_IM]);
      re = clamp_q(longint'(col) * as_q(shadow_regs[ajet_pkg::CSR_STEP_X])
                   + as_q(shadow_regs[ajet_pkg::CSR_ORIGIN_X]));
      im = clamp_q(longint'(row) * as_q(shadow_regs[ajet_pkg::CSR_STEP_Y])
                   + as_q(shadow_regs[ajet_pkg::CSR_ORIGIN_Y]));
      count = 0;
      while (1) begin
         ar = (re < 0) ? -re : re;
         ai = (im < 0) ? -im : im;
         r2 = ar * ar;
         i2 = ai * ai;
         if (r2 + i2 >= ESCAPE_BOUND || count >= limit_iter) break;
         d = longint'(r2) - longint'(i2);
         p = longint'(ai) * re;
         re = clamp_q((d >>> ajet_pkg::FRAC_BITS) + cr);
         im = clamp_q((p >>> (ajet_pkg::FRAC_BITS - 1)) + ci);
         count++;
      end
      res.iteration_count = count_type'(count);
      res.inside_res = (count == limit_iter);
      if (res.inside_res) begin
         res.blue = '0;
         res.green = '0;
         res.red = '0;
      end else begin
         res.blue = color_type'(count * gains[7:0]);
         res.green = color_type'(count * gains[15:8]);
         res.red = color_type'(count * gains[23:16]);
      end
      return res;
   endfunction

   function automatic void compare_field(input string field, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         error_count++;
      end
   endfunction

   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic csr_expect(input ajet_pkg::csr_index_type idx);
      logic [ajet_pkg::CSR_DATA_W-1:0] got;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      got = prdata & reg_mask(idx);
      compare_field(idx.name(), shadow_regs[idx], got);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_write(input ajet_pkg::csr_index_type idx,
                            input logic [ajet_pkg::CSR_DATA_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      shadow_regs[idx] = value & reg_mask(idx);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      csr_expect(idx);
   endtask

   task automatic set_view(input logic [31:0] c_re, input logic [31:0] c_im,
                           input logic [31:0] org_x, input logic [31:0] org_y,
                           input logic [31:0] st_x, input logic [31:0] st_y,
                           input logic [31:0] iter_limit, input logic [31:0] gains);
      csr_write(ajet_pkg::CSR_C_RE, c_re);
      csr_write(ajet_pkg::CSR_C_IM, c_im);
      csr_write(ajet_pkg::CSR_ORIGIN_X, org_x);
      csr_write(ajet_pkg::CSR_ORIGIN_Y, org_y);
      csr_write(ajet_pkg::CSR_STEP_X, st_x);
      csr_write(ajet_pkg::CSR_STEP_Y, st_y);
      csr_write(ajet_pkg::CSR_MAX_ITER, iter_limit);
      csr_write(ajet_pkg::CSR_COLOR_GAINS, gains);
   endtask

   task automatic send_pixel(input int col, input int row);
      int              gap;
      pixel_coord_type col_bits;
      pixel_coord_type row_bits;
      col_bits = pixel_coord_type'(col);
      row_bits = pixel_coord_type'(row);
      gap = no_idling ? 0 : idle_length();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.pixel_x <= col_bits;
      req_bus.pixel_y <= row_bits;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      expected_pixels.push_back(escape_time(col_bits, row_bits));
   endtask

   task automatic send_random_pixel();
      send_pixel(int'($urandom_range(0, PIXEL_MAX)), int'($urandom_range(0, PIXEL_MAX)));
   endtask

   task automatic settle_pixels();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_pixels.size() != 0) @(posedge clock);
   endtask

   task automatic test_reset_values();
      for (int i = 0; i < CSR_COUNT; i++) csr_expect(ajet_pkg::csr_index_type'(i));
      send_pixel(0, 0);
      send_pixel(PIXEL_MAX, PIXEL_MAX);
      settle_pixels();
   endtask

   task automatic test_extreme_pixels();
      set_view(32'hFF40_0000, 32'h0019_999A, 32'hFE00_0000, 32'hFE00_0000,
               32'h0001_0000, 32'h0001_0000, 50, 32'h0012_3456);
      send_pixel(0, 0);
      send_pixel(PIXEL_MAX, 0);
      send_pixel(0, PIXEL_MAX);
      send_pixel(PIXEL_MAX, PIXEL_MAX);
      send_pixel(512, 512);
      send_pixel(32'h155, 32'h2AA);
      send_pixel(32'h2AA, 32'h155);
      settle_pixels();
   endtask

   task automatic test_zero_limit();
      csr_write(ajet_pkg::CSR_MAX_ITER, 0);
      csr_write(ajet_pkg::CSR_COLOR_GAINS, 32'h00FF_FFFF);
      send_pixel(5, 9);
      send_pixel(PIXEL_MAX, 0);
      settle_pixels();
   endtask

   task automatic test_saturation();
      set_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
               32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_FFFF, 32'h00FF_FFFF);
      send_pixel(PIXEL_MAX, PIXEL_MAX);
      send_pixel(0, 0);
      settle_pixels();
      set_view(32'h7FFF_FFFF, 32'h8000_0000, 0, 0,
               32'hFF00_0000, 32'h0100_0000, 10, 32'h0080_4001);
      send_pixel(1, 1);
      send_pixel(2, 0);
      send_pixel(0, 0);
      settle_pixels();
   endtask

   task automatic test_long_limit();
      set_view(0, 0, 0, 0, 0, 0, 32'h0000_FFFF, 32'h0001_0203);
      send_pixel(32'h2AA, 32'h155);
      settle_pixels();
   endtask

   task automatic test_random_views();
      int step_x;
      int step_y;
      int org_x;
      int org_y;
      for (int v = 0; v < 6; v++) begin
         if (v == 5) begin
            set_view($urandom(), $urandom(), $urandom(), $urandom(),
                     $urandom(), $urandom(), $urandom_range(1, 64), $urandom());
         end else begin
            step_x = $urandom_range(1 << 12, 1 << 17);
            step_y = $urandom_range(1 << 12, 1 << 17);
            if ($urandom_range(0, 3) == 0) step_x = -step_x;
            if ($urandom_range(0, 3) == 0) step_y = -step_y;
            org_x = -(step_x * 512) + int'($urandom_range(0, 1 << 24)) - (1 << 23);
            org_y = -(step_y * 512) + int'($urandom_range(0, 1 << 24)) - (1 << 23);
            set_view(int'($urandom_range(0, 1 << 26)) - (1 << 25),
                     int'($urandom_range(0, 1 << 26)) - (1 << 25),
                     org_x, org_y, step_x, step_y,
                     (v == 0) ? 1 : $urandom_range(2, 64), $urandom());
         end
         repeat (70) send_random_pixel();
         settle_pixels();
      end
   endtask

   task automatic test_back_to_back();
      set_view(32'hFF40_0000, 32'h0019_999A, 32'hFE00_0000, 32'hFE00_0000,
               32'h0001_0000, 32'h0001_0000, 30, 32'h0005_0B11);
      no_idling = 1'b1;
      repeat (40) send_random_pixel();
      no_idling = 1'b0;
      settle_pixels();
   endtask

   task automatic test_output_stall();
      csr_write(ajet_pkg::CSR_MAX_ITER, 20);
      no_idling = 1'b1;
      rsp_hold_cycles = 400;
      repeat (15) send_random_pixel();
      no_idling = 1'b0;
      settle_pixels();
   endtask

   initial begin : rsp_stall_driver
      int stall_left;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            stall_left = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else if (stall_left == 0 && !no_idling && $urandom_range(0, 3) == 0) begin
            stall_left = idle_length();
         end
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin : pixel_result_checker
      pixel_result_type want;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (expected_pixels.size() == 0) begin
               $error("result transfer with no pixel pending");
               error_count++;
            end else begin
               want = expected_pixels.pop_front();
               compare_field("iteration_count", 32'(want.iteration_count),
                             32'(rsp_bus.iteration_count));
               compare_field("inside_res", 32'(want.inside_res), 32'(rsp_bus.inside_res));
               compare_field("blue", 32'(want.blue), 32'(rsp_bus.blue));
               compare_field("green", 32'(want.green), 32'(rsp_bus.green));
               compare_field("red", 32'(want.red), 32'(rsp_bus.red));
            end
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
             || (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : run_tests
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.pixel_x <= '0;
      req_bus.pixel_y <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      for (int i = 0; i < CSR_COUNT; i++) shadow_regs[i] = '0;
      shadow_regs[ajet_pkg::CSR_MAX_ITER] = 32'(ajet_pkg::MAX_ITER_RESET);
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_extreme_pixels();
      test_zero_limit();
      test_saturation();
      test_long_limit();
      test_random_views();
      test_back_to_back();
      test_output_stall();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
